/* rtl/core/lcdsd_pkg.sv */
// Shared types, constants and window decode functions for the LCD serial deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package lcdsd_pkg;

  localparam logic [7:0] SYNC_CMD    = 8'hF8;
  localparam logic [7:0] SYNC_DATA   = 8'hFA;
  localparam logic [7:0] CMD_BIT     = 8'h80;
  localparam logic [7:0] LIMIT_RESET = 8'd38;
  localparam int         FIFO_DEPTH  = 4;
  localparam int         WIN_DEPTH   = 4;

  typedef enum logic [1:0] {
    PH_SEARCH  = 2'd0,
    PH_ALIGNED = 2'd1,
    PH_SHIFTED = 2'd2,
    PH_GAVEUP  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_SET_ADDR = 2'd0,
    EV_DATA     = 2'd1,
    EV_UNKNOWN  = 2'd2,
    EV_GAVE_UP  = 2'd3
  } kind_t;

  // what the front hands to the back
  typedef enum logic [1:0] {
    ENT_BYTE   = 2'd0,
    ENT_LOCK   = 2'd1,
    ENT_GIVEUP = 2'd2
  } ent_kind_t;

  typedef struct packed {
    ent_kind_t  kind;
    logic [7:0] raw;
    logic       shift;
  } ent_t;

  typedef enum logic [1:0] {
    ACT_WAIT      = 2'd0,
    ACT_SYNC_CMD  = 2'd1,
    ACT_SYNC_DATA = 2'd2,
    ACT_EMIT      = 2'd3
  } act_t;

  typedef logic [WIN_DEPTH-1:0][7:0] win_t;

  typedef struct packed {
    act_t       act;
    kind_t      kind;
    logic [7:0] vert;
    logic [4:0] hor;
    logic [7:0] data;
    logic [2:0] used;
  } step_t;

  // One decode step on the head of the window.
  function automatic step_t win_step(input win_t w, input logic [2:0] cnt, input logic mode,
                                     input logic acs, input logic ads, input logic s);
    logic [7:0] syc;
    logic [7:0] syd;
    logic [7:0] cbit;
    logic [7:0] v0;
    step_t      st;
    syc  = s ? (SYNC_CMD >> 1) : SYNC_CMD;
    syd  = s ? (SYNC_DATA >> 1) : SYNC_DATA;
    cbit = s ? (CMD_BIT >> 1) : CMD_BIT;
    v0   = w[0] & ~cbit;
    st      = '0;
    st.act  = ACT_WAIT;
    st.kind = EV_SET_ADDR;
    if (cnt != 3'd0) begin
      if (!acs && !ads && w[0] == syc) begin
        st.act  = ACT_SYNC_CMD;
        st.used = 3'd1;
      end else if (!ads && w[0] == syd) begin
        st.act  = ACT_SYNC_DATA;
        st.used = 3'd1;
      end else if (!mode) begin
        if ((w[0] & cbit) == 8'd0) begin
          st.act  = ACT_EMIT;
          st.kind = EV_UNKNOWN;
          st.used = 3'd1;
        end else if (cnt >= 3'd3) begin
          if ((w[2] & cbit) == 8'd0) begin
            st.act  = ACT_EMIT;
            st.kind = EV_UNKNOWN;
            st.used = 3'd1;
          end else if (cnt >= 3'd4) begin
            st.act  = ACT_EMIT;
            st.kind = EV_SET_ADDR;
            st.used = 3'd4;
            st.vert = s ? ({v0[6:0], 1'b0} | {3'b000, w[1][7:3]})
                        : (v0 | {4'b0000, w[1][7:4]});
            st.hor  = s ? w[3][7:3] : {1'b0, w[3][7:4]};
          end
        end
      end else if (cnt >= 3'd2) begin
        st.act  = ACT_EMIT;
        st.kind = EV_DATA;
        st.used = 3'd2;
        st.data = s ? ({w[0][6:0], 1'b0} | {3'b000, w[1][7:3]})
                    : (w[0] | {4'b0000, w[1][7:4]});
      end
    end
    return st;
  endfunction

  function automatic win_t shift_win(input win_t w, input logic [2:0] used);
    win_t r;
    unique case (used)
      3'd1:    r = w >> 8;
      3'd2:    r = w >> 16;
      3'd4:    r = '0;
      default: r = w;
    endcase
    return r;
  endfunction

  // True if the window still yields an event before it runs dry; only syncs
  // can precede it, and at most three bytes remain.
  function automatic logic more_results(input win_t w, input logic [2:0] cnt,
                                        input logic mode, input logic acs,
                                        input logic ads, input logic s);
    win_t       ww;
    logic [2:0] cc;
    logic       md;
    logic       ac;
    logic       ad;
    logic       stop;
    logic       found;
    step_t      st;
    ww    = w;
    cc    = cnt;
    md    = mode;
    ac    = acs;
    ad    = ads;
    stop  = 1'b0;
    found = 1'b0;
    for (int i = 0; i < WIN_DEPTH - 1; i++) begin
      st = win_step(ww, cc, md, ac, ad, s);
      if (!stop) begin
        unique case (st.act)
          ACT_SYNC_CMD: begin
            md = 1'b0;
            ac = 1'b1;
            ww = ww >> 8;
            cc = cc - 3'd1;
          end
          ACT_SYNC_DATA: begin
            md = 1'b1;
            ac = 1'b0;
            ad = 1'b1;
            ww = ww >> 8;
            cc = cc - 3'd1;
          end
          ACT_EMIT: begin
            found = 1'b1;
            stop  = 1'b1;
          end
          default: stop = 1'b1;
        endcase
      end
    end
    return found;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lcd_serial_frame_deframer.sv */
// Top level of the LCD serial link deframer: front, word queue and back.
// Depends on lcdsd_pkg, lcdsd_front, lcdsd_fifo and lcdsd_back.
//
// Input channel (byte_valid/byte_ready): one sniffed byte per word with
// capture_start marking the first byte of a capture. Output channel
// (event_valid/event_ready): one decoded event per word, last set on the
// final event caused by an input byte.
// Throughput: one byte per cycle while the queue is not full; the back end
// makes one window step per cycle (an event or a mode sync), merging the
// first with the arrival of a new byte, so a byte that leaves several steps
// (up to three events) holds the back end until all its steps are done.
// With an idle back end, the byte that completes an event is queued at the
// accepting edge and then loaded from the queue head into the output register.
// When the receiver stalls, the event register holds, the back end stops
// and the queue (FIFO_DEPTH words) fills; byte_ready drops once it is full.
// Reset: sync search restarts, the queue empties, search_limit returns to 38.
// No clearing pass is needed; the block takes bytes in the cycle after reset.
// cfg_wen/cfg_wdata write search_limit; write only while the block is idle.
`default_nettype none

module lcd_serial_frame_deframer
  import lcdsd_pkg::*;
#(
  parameter int FIFO_DEPTH_P = FIFO_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_ready,
  input  wire logic [7:0] raw_byte,
  input  wire logic       capture_start,
  output logic            event_valid,
  input  wire logic       event_ready,
  output logic [1:0]      event_kind,
  output logic [7:0]      row_addr,
  output logic [4:0]      col_addr,
  output logic [7:0]      data_byte,
  output logic            last,
  input  wire logic       cfg_wen,
  input  wire logic [7:0] cfg_wdata
);

  logic q_full;
  logic push;
  ent_t push_ent;
  ent_t head;
  logic head_valid;
  logic pop;

  lcdsd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_ready    (byte_ready),
    .raw_byte      (raw_byte),
    .capture_start (capture_start),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .q_full        (q_full),
    .push          (push),
    .push_ent      (push_ent)
  );

  lcdsd_fifo #(
    .DEPTH (FIFO_DEPTH_P)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ent   (push_ent),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full)
  );

  lcdsd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .event_kind  (event_kind),
    .row_addr    (row_addr),
    .col_addr    (col_addr),
    .data_byte   (data_byte),
    .last        (last)
  );

endmodule

`default_nettype wire

/* rtl/core/lcdsd_fifo.sv */
// Short word queue between the front and back parts of the deframer.
// Depends on lcdsd_pkg for the entry type.
`default_nettype none

module lcdsd_fifo
  import lcdsd_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire ent_t push_ent,
  input  wire logic pop,
  output ent_t      head,
  output logic      head_valid,
  output logic      full
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  ent_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  assign head       = mem[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == CW'(DEPTH));

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CW'(1);
    end else if (pop && !push) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_ent;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lcdsd_front.sv */
// Front part: takes sniffed bytes, runs the sync search and turns search
// results and post-lock bytes into queue words. Depends on lcdsd_pkg.
`default_nettype none

module lcdsd_front
  import lcdsd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_ready,
  input  wire logic [7:0] raw_byte,
  input  wire logic       capture_start,
  input  wire logic       cfg_wen,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       q_full,
  output logic            push,
  output ent_t            push_ent
);

  phase_t     phase;
  phase_t     phase_next;
  phase_t     phase_eff;
  logic [7:0] search_count;
  logic [7:0] search_count_next;
  logic [7:0] scnt_eff;
  logic [7:0] search_limit;
  logic       accept;

  assign byte_ready = !q_full;
  assign accept     = byte_valid && byte_ready;

  always_comb begin
    phase_eff         = capture_start ? PH_SEARCH : phase;
    scnt_eff          = capture_start ? 8'd0 : search_count;
    phase_next        = phase;
    search_count_next = search_count;
    push              = 1'b0;
    push_ent.kind     = ENT_BYTE;
    push_ent.raw      = raw_byte;
    push_ent.shift    = 1'b0;
    if (accept) begin
      phase_next        = phase_eff;
      search_count_next = scnt_eff;
      unique case (phase_eff) inside
        PH_SEARCH: begin
          // aligned sync wins over the shifted form
          if ((raw_byte & SYNC_CMD) == SYNC_CMD) begin
            phase_next    = PH_ALIGNED;
            push          = 1'b1;
            push_ent.kind = ENT_LOCK;
          end else if ((raw_byte & (SYNC_CMD >> 1)) == (SYNC_CMD >> 1)) begin
            phase_next     = PH_SHIFTED;
            push           = 1'b1;
            push_ent.kind  = ENT_LOCK;
            push_ent.shift = 1'b1;
          end else if (scnt_eff < search_limit) begin
            search_count_next = scnt_eff + 8'd1;
          end else begin
            phase_next    = PH_GAVEUP;
            push          = 1'b1;
            push_ent.kind = ENT_GIVEUP;
          end
        end
        PH_ALIGNED, PH_SHIFTED: begin
          push = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SEARCH;
      search_count <= 8'd0;
      search_limit <= LIMIT_RESET;
    end else begin
      phase        <= phase_next;
      search_count <= search_count_next;
      if (cfg_wen) begin
        search_limit <= cfg_wdata;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lcdsd_back.sv */
// Back part: keeps the four-byte window, follows mode syncs and decodes
// events into the output register. Depends on lcdsd_pkg.
`default_nettype none

module lcdsd_back
  import lcdsd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire ent_t  head,
  input  wire logic  head_valid,
  output logic       pop,
  output logic       event_valid,
  input  wire logic  event_ready,
  output logic [1:0] event_kind,
  output logic [7:0] row_addr,
  output logic [4:0] col_addr,
  output logic [7:0] data_byte,
  output logic       last
);

  win_t       win;
  win_t       win_next;
  logic [2:0] cnt;
  logic [2:0] cnt_next;
  logic       mode;
  logic       mode_next;
  logic       acs;
  logic       acs_next;
  logic       ads;
  logic       ads_next;
  logic       shifted;
  logic       shifted_next;

  logic       go;
  logic       load;
  logic       use_app;
  win_t       w_app;
  logic [2:0] cnt_app;
  step_t      st_win;
  step_t      st_app;
  step_t      st_sel;
  win_t       w_sel;
  logic [2:0] cnt_sel;
  win_t       w_post;
  logic [2:0] cnt_post;
  logic       mode_post;
  logic       acs_post;
  logic       ads_post;
  logic       more;
  kind_t      kind_ld;
  logic [7:0] vert_ld;
  logic [4:0] hor_ld;
  logic [7:0] data_ld;
  logic       last_ld;

  always_comb begin
    go      = !event_valid || event_ready;
    st_win  = win_step(win, cnt, mode, acs, ads, shifted);
    w_app   = win;
    w_app[cnt[1:0]] = head.raw;
    cnt_app = cnt + 3'd1;
    st_app  = win_step(w_app, cnt_app, mode, acs, ads, shifted);
    // window stalled on lookahead: the next queued byte joins it this cycle
    use_app = (st_win.act == ACT_WAIT) && head_valid && (head.kind == ENT_BYTE);
    w_sel   = use_app ? w_app : win;
    cnt_sel = use_app ? cnt_app : cnt;
    st_sel  = use_app ? st_app : st_win;

    w_post    = shift_win(w_sel, st_sel.used);
    cnt_post  = cnt_sel - st_sel.used;
    mode_post = mode;
    acs_post  = acs;
    ads_post  = ads;
    unique case (st_sel.act)
      ACT_SYNC_CMD: begin
        mode_post = 1'b0;
        acs_post  = 1'b1;
      end
      ACT_SYNC_DATA: begin
        mode_post = 1'b1;
        acs_post  = 1'b0;
        ads_post  = 1'b1;
      end
      ACT_EMIT: begin
        acs_post = 1'b0;
        ads_post = 1'b0;
      end
      default: ;
    endcase
    more = more_results(w_post, cnt_post, mode_post, acs_post, ads_post, shifted);

    win_next     = win;
    cnt_next     = cnt;
    mode_next    = mode;
    acs_next     = acs;
    ads_next     = ads;
    shifted_next = shifted;
    pop          = 1'b0;
    load         = 1'b0;
    kind_ld      = st_sel.kind;
    vert_ld      = st_sel.vert;
    hor_ld       = st_sel.hor;
    data_ld      = st_sel.data;
    last_ld      = !more;

    if (go) begin
      if (st_win.act != ACT_WAIT || use_app) begin
        pop       = use_app;
        win_next  = w_post;
        cnt_next  = cnt_post;
        mode_next = mode_post;
        acs_next  = acs_post;
        ads_next  = ads_post;
        load      = (st_sel.act == ACT_EMIT);
      end else if (head_valid) begin
        pop = 1'b1;
        unique case (head.kind)
          ENT_LOCK: begin
            cnt_next     = 3'd0;
            mode_next    = 1'b0;
            acs_next     = 1'b0;
            ads_next     = 1'b0;
            shifted_next = head.shift;
          end
          ENT_GIVEUP: begin
            load    = 1'b1;
            kind_ld = EV_GAVE_UP;
            vert_ld = 8'd0;
            hor_ld  = 5'd0;
            data_ld = 8'd0;
            last_ld = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= 3'd0;
      mode        <= 1'b0;
      acs         <= 1'b0;
      ads         <= 1'b0;
      shifted     <= 1'b0;
      event_valid <= 1'b0;
    end else begin
      cnt     <= cnt_next;
      mode    <= mode_next;
      acs     <= acs_next;
      ads     <= ads_next;
      shifted <= shifted_next;
      if (load) begin
        event_valid <= 1'b1;
      end else if (event_ready) begin
        event_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    win <= win_next;
    if (load) begin
      event_kind <= kind_ld;
      row_addr   <= vert_ld;
      col_addr   <= hor_ld;
      data_byte  <= data_ld;
      last       <= last_ld;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lcdsd_checker.sv */
// Port-level checks for the LCD serial deframer, bound to the top level.
// Depends on lcdsd_pkg for the event codes.
`default_nettype none

module lcdsd_checker
  import lcdsd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       byte_ready,
  input wire logic       event_valid,
  input wire logic       event_ready,
  input wire logic [1:0] event_kind,
  input wire logic [7:0] row_addr,
  input wire logic [4:0] col_addr,
  input wire logic [7:0] data_byte,
  input wire logic       last
);

  // a stalled event word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    event_valid && !event_ready |=> event_valid && $stable(event_kind)
      && $stable(row_addr) && $stable(col_addr) && $stable(data_byte) && $stable(last))
    else $error("event word changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !event_valid)
    else $error("event valid right after reset");

  // queue is empty after reset, so input is open
  a_ready_reset: assert property (@(posedge clk) rst |=> byte_ready)
    else $error("byte ready low right after reset");

  // giving up is always the only event of its byte
  a_giveup_last: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_kind == EV_GAVE_UP |-> last)
    else $error("gave-up event without last");

  // fields that do not belong to the event kind read as zero
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    event_valid |-> (event_kind == EV_DATA || data_byte == 8'd0)
      && (event_kind == EV_SET_ADDR || (row_addr == 8'd0 && col_addr == 5'd0)))
    else $error("unused event field not zero");

endmodule

bind lcd_serial_frame_deframer lcdsd_checker u_chk (.*);

`default_nettype wire
